### hw/rtl/mipsex_pkg.sv
package mipsex_pkg;

  localparam int DataWidth = 32;
  localparam int RegIndexWidth = 5;
  localparam int OpWidth = 5;
  localparam int SelWidth = 2;
  localparam int ImmLowWidth = 16;
  localparam int LuiShift = 16;

  localparam logic [OpWidth-1:0] OP_ADD        = 5'd0;
  localparam logic [OpWidth-1:0] OP_ADDU       = 5'd1;
  localparam logic [OpWidth-1:0] OP_ADDI       = 5'd2;
  localparam logic [OpWidth-1:0] OP_SUB        = 5'd3;
  localparam logic [OpWidth-1:0] OP_SUBU       = 5'd4;
  localparam logic [OpWidth-1:0] OP_AND        = 5'd5;
  localparam logic [OpWidth-1:0] OP_ANDI       = 5'd6;
  localparam logic [OpWidth-1:0] OP_OR         = 5'd7;
  localparam logic [OpWidth-1:0] OP_ORI        = 5'd8;
  localparam logic [OpWidth-1:0] OP_XOR        = 5'd9;
  localparam logic [OpWidth-1:0] OP_XORI       = 5'd10;
  localparam logic [OpWidth-1:0] OP_LUI        = 5'd11;
  localparam logic [OpWidth-1:0] OP_LOAD_FIRST = 5'd12;
  localparam logic [OpWidth-1:0] OP_LOAD_LAST  = 5'd17;
  localparam logic [OpWidth-1:0] OP_STORE_FIRST = 5'd18;
  localparam logic [OpWidth-1:0] OP_STORE_LAST = 5'd20;
  localparam logic [OpWidth-1:0] OP_BEQ        = 5'd21;
  localparam logic [OpWidth-1:0] OP_BNE        = 5'd22;
  localparam logic [OpWidth-1:0] OP_J          = 5'd23;
  localparam logic [OpWidth-1:0] OP_OTHER_R    = 5'd24;
  localparam logic [OpWidth-1:0] OP_OTHER_I    = 5'd25;

  localparam logic [SelWidth-1:0] FWD_REG   = 2'd0;
  localparam logic [SelWidth-1:0] FWD_PREV  = 2'd1;
  localparam logic [SelWidth-1:0] FWD_OLDER = 2'd2;

endpackage

### hw/rtl/mips_execute_stage_forwarding.sv
// Execute stage of a 32-bit MIPS subset with operand forwarding.
// The input channel (valid, stall) carries one ID/EX slot per transfer, bubbles
// included: the in_valid field marks a real instruction, and a bubble still
// takes a transfer and yields a result with every field zero.
// The result channel (res_valid, res_stall) carries one result per input slot,
// in order, with out_valid copying in_valid.
// Each slot is captured in an input register, evaluated combinationally by the
// operand select, ALU and branch compare, and lands in the result register.
// Throughput is one slot per cycle while the receiver does not stall, set by
// the single pass from input register to result register.
// The block keeps the ALU results and load flags of the last two slots as the
// forwarding sources; they advance when a slot moves into the result register.
// Reset clears both registers' valid flags and the forwarding history to zero.
// When the receiver stalls, the result holds; the input register still takes
// one more slot, and after that stall is raised until the result drains.
module mips_execute_stage_forwarding import mipsex_pkg::*; #(
  parameter int DATA_WIDTH = DataWidth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  output logic                     stall,
  input  logic                     in_valid,
  input  logic [OpWidth-1:0]       op,
  input  logic [DATA_WIDTH-1:0]    reg_value_a,
  input  logic [DATA_WIDTH-1:0]    reg_value_b,
  input  logic [SelWidth-1:0]      forward_sel_a,
  input  logic [SelWidth-1:0]      forward_sel_b,
  input  logic signed [DATA_WIDTH-1:0] immediate,
  input  logic [RegIndexWidth-1:0] rd_index,
  input  logic [RegIndexWidth-1:0] rt_index,
  input  logic [DATA_WIDTH-1:0]    pc_plus_four,
  input  logic [DATA_WIDTH-1:0]    jump_target,
  input  logic [DATA_WIDTH-1:0]    load_data_two_back,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic                     out_valid,
  output logic [DATA_WIDTH-1:0]    alu_value,
  output logic [DATA_WIDTH-1:0]    store_value,
  output logic [RegIndexWidth-1:0] dest_index,
  output logic                     is_branch,
  output logic                     taken,
  output logic [DATA_WIDTH-1:0]    target
);

  logic                     slot_full;
  logic                     slot_valid;
  logic [OpWidth-1:0]       slot_op;
  logic [DATA_WIDTH-1:0]    slot_reg_a;
  logic [DATA_WIDTH-1:0]    slot_reg_b;
  logic [SelWidth-1:0]      slot_sel_a;
  logic [SelWidth-1:0]      slot_sel_b;
  logic [DATA_WIDTH-1:0]    slot_imm;
  logic [RegIndexWidth-1:0] slot_rd;
  logic [RegIndexWidth-1:0] slot_rt;
  logic [DATA_WIDTH-1:0]    slot_pc4;
  logic [DATA_WIDTH-1:0]    slot_jump;
  logic [DATA_WIDTH-1:0]    slot_load_data;

  logic [DATA_WIDTH-1:0]    prev_result;
  logic                     prev_was_load;
  logic [DATA_WIDTH-1:0]    older_result;
  logic                     older_was_load;

  logic                     in_take;
  logic                     slot_move;
  logic                     res_free;

  logic [DATA_WIDTH-1:0]    older_value;
  logic [DATA_WIDTH-1:0]    opnd_a;
  logic [DATA_WIDTH-1:0]    opnd_b;
  logic [DATA_WIDTH-1:0]    imm_low;
  logic [DATA_WIDTH-1:0]    cond_target;
  logic                     op_load;
  logic                     op_store;
  logic [DATA_WIDTH-1:0]    alu_next;
  logic [RegIndexWidth-1:0] dest_next;
  logic                     branch_next;
  logic                     taken_next;
  logic [DATA_WIDTH-1:0]    target_next;

  assign res_free  = !res_valid || !res_stall;
  assign slot_move = slot_full && res_free;
  assign stall     = slot_full && !res_free;
  assign in_take   = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= 1'b0;
    end else if (in_take) begin
      slot_full <= 1'b1;
    end else if (slot_move) begin
      slot_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_valid     <= in_valid;
      slot_op        <= op;
      slot_reg_a     <= reg_value_a;
      slot_reg_b     <= reg_value_b;
      slot_sel_a     <= forward_sel_a;
      slot_sel_b     <= forward_sel_b;
      slot_imm       <= immediate;
      slot_rd        <= rd_index;
      slot_rt        <= rt_index;
      slot_pc4       <= pc_plus_four;
      slot_jump      <= jump_target;
      slot_load_data <= load_data_two_back;
    end
  end

  always_comb begin
    older_value = older_was_load ? slot_load_data : older_result;

    unique case (slot_sel_a)
      FWD_PREV:  opnd_a = prev_result;
      FWD_OLDER: opnd_a = older_value;
      default:   opnd_a = slot_reg_a;
    endcase

    unique case (slot_sel_b)
      FWD_PREV:  opnd_b = prev_result;
      FWD_OLDER: opnd_b = older_value;
      default:   opnd_b = slot_reg_b;
    endcase
  end

  assign imm_low     = DATA_WIDTH'(slot_imm[ImmLowWidth-1:0]);
  assign cond_target = slot_pc4 + slot_imm;
  assign op_load     = (slot_op >= OP_LOAD_FIRST) && (slot_op <= OP_LOAD_LAST);
  assign op_store    = (slot_op >= OP_STORE_FIRST) && (slot_op <= OP_STORE_LAST);

  always_comb begin
    alu_next    = '0;
    dest_next   = '0;
    branch_next = 1'b0;
    taken_next  = 1'b0;
    target_next = '0;
    unique case (slot_op)
      OP_ADD, OP_ADDU: begin
        alu_next  = opnd_a + opnd_b;
        dest_next = slot_rd;
      end
      OP_ADDI: begin
        alu_next  = opnd_a + slot_imm;
        dest_next = slot_rt;
      end
      OP_SUB, OP_SUBU: begin
        alu_next  = opnd_a - opnd_b;
        dest_next = slot_rd;
      end
      OP_AND: begin
        alu_next  = opnd_a & opnd_b;
        dest_next = slot_rd;
      end
      OP_ANDI: begin
        alu_next  = opnd_a & imm_low;
        dest_next = slot_rt;
      end
      OP_OR: begin
        alu_next  = opnd_a | opnd_b;
        dest_next = slot_rd;
      end
      OP_ORI: begin
        alu_next  = opnd_a | imm_low;
        dest_next = slot_rt;
      end
      OP_XOR: begin
        alu_next  = opnd_a ^ opnd_b;
        dest_next = slot_rd;
      end
      OP_XORI: begin
        alu_next  = opnd_a ^ imm_low;
        dest_next = slot_rt;
      end
      OP_LUI: begin
        alu_next  = slot_imm << LuiShift;
        dest_next = slot_rt;
      end
      OP_BEQ: begin
        branch_next = 1'b1;
        taken_next  = (opnd_a == opnd_b);
        target_next = cond_target;
      end
      OP_BNE: begin
        branch_next = 1'b1;
        taken_next  = (opnd_a != opnd_b);
        target_next = cond_target;
      end
      OP_J: begin
        branch_next = 1'b1;
        taken_next  = 1'b1;
        target_next = slot_jump;
      end
      OP_OTHER_R: begin
        dest_next = slot_rd;
      end
      OP_OTHER_I: begin
        dest_next = slot_rt;
      end
      default: begin
        if (op_load) begin
          alu_next  = opnd_a + slot_imm;
          dest_next = slot_rt;
        end else if (op_store) begin
          alu_next = opnd_a + slot_imm;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid      <= 1'b0;
      prev_result    <= '0;
      prev_was_load  <= 1'b0;
      older_result   <= '0;
      older_was_load <= 1'b0;
    end else begin
      if (slot_move) begin
        res_valid      <= 1'b1;
        older_result   <= prev_result;
        older_was_load <= prev_was_load;
        prev_result    <= slot_valid ? alu_next : '0;
        prev_was_load  <= slot_valid && op_load;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_move) begin
      out_valid   <= slot_valid;
      alu_value   <= slot_valid ? alu_next : '0;
      store_value <= slot_valid ? opnd_b : '0;
      dest_index  <= slot_valid ? dest_next : '0;
      is_branch   <= slot_valid && branch_next;
      taken       <= slot_valid && taken_next;
      target      <= slot_valid ? target_next : '0;
    end
  end

endmodule

### test/execute_result_checker.sv
`timescale 1ns / 100ps

module execute_result_checker import mipsex_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  input  logic                     stall,
  input  logic                     in_valid,
  input  logic [OpWidth-1:0]       op,
  input  logic [DataWidth-1:0]     reg_value_a,
  input  logic [DataWidth-1:0]     reg_value_b,
  input  logic [SelWidth-1:0]      forward_sel_a,
  input  logic [SelWidth-1:0]      forward_sel_b,
  input  logic [DataWidth-1:0]     immediate,
  input  logic [RegIndexWidth-1:0] rd_index,
  input  logic [RegIndexWidth-1:0] rt_index,
  input  logic [DataWidth-1:0]     pc_plus_four,
  input  logic [DataWidth-1:0]     jump_target,
  input  logic [DataWidth-1:0]     load_data_two_back,
  input  logic                     res_valid,
  input  logic                     res_stall,
  input  logic                     out_valid,
  input  logic [DataWidth-1:0]     alu_value,
  input  logic [DataWidth-1:0]     store_value,
  input  logic [RegIndexWidth-1:0] dest_index,
  input  logic                     is_branch,
  input  logic                     taken,
  input  logic [DataWidth-1:0]     target,
  output int                       mismatch_count,
  output int                       outstanding
);

  typedef struct packed {
    logic                     out_valid;
    logic [DataWidth-1:0]     alu_value;
    logic [DataWidth-1:0]     store_value;
    logic [RegIndexWidth-1:0] dest_index;
    logic                     is_branch;
    logic                     taken;
    logic [DataWidth-1:0]     target;
  } exec_result_t;

  exec_result_t predicted_results[$];

  // Stand-ins for the EX/MEM and MEM/WB latches.
  logic [DataWidth-1:0] last_alu;
  logic                 last_was_load;
  logic [DataWidth-1:0] older_alu;
  logic                 older_was_load;
  int                   result_index;

  function automatic logic [DataWidth-1:0] select_operand(logic [SelWidth-1:0] sel,
                                                          logic [DataWidth-1:0] reg_value);
    if (sel == FWD_PREV) begin
      return last_alu;
    end
    if (sel == FWD_OLDER) begin
      return older_was_load ? load_data_two_back : older_alu;
    end
    return reg_value;
  endfunction

  task automatic execute_slot(output exec_result_t r);
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic [DataWidth-1:0] imm_low;
    logic                 is_load;
    r = '0;
    a = select_operand(forward_sel_a, reg_value_a);
    b = select_operand(forward_sel_b, reg_value_b);
    imm_low = {{(DataWidth-ImmLowWidth){1'b0}}, immediate[ImmLowWidth-1:0]};
    is_load = (op >= OP_LOAD_FIRST) && (op <= OP_LOAD_LAST);
    older_alu = last_alu;
    older_was_load = last_was_load;
    if (!in_valid) begin
      last_alu = '0;
      last_was_load = 1'b0;
      return;
    end
    r.out_valid = 1'b1;
    r.store_value = b;
    case (op)
      OP_ADD, OP_ADDU: begin
        r.alu_value = a + b;
        r.dest_index = rd_index;
      end
      OP_ADDI: begin
        r.alu_value = a + immediate;
        r.dest_index = rt_index;
      end
      OP_SUB, OP_SUBU: begin
        r.alu_value = a - b;
        r.dest_index = rd_index;
      end
      OP_AND: begin
        r.alu_value = a & b;
        r.dest_index = rd_index;
      end
      OP_ANDI: begin
        r.alu_value = a & imm_low;
        r.dest_index = rt_index;
      end
      OP_OR: begin
        r.alu_value = a | b;
        r.dest_index = rd_index;
      end
      OP_ORI: begin
        r.alu_value = a | imm_low;
        r.dest_index = rt_index;
      end
      OP_XOR: begin
        r.alu_value = a ^ b;
        r.dest_index = rd_index;
      end
      OP_XORI: begin
        r.alu_value = a ^ imm_low;
        r.dest_index = rt_index;
      end
      OP_LUI: begin
        r.alu_value = immediate << LuiShift;
        r.dest_index = rt_index;
      end
      OP_BEQ: begin
        r.is_branch = 1'b1;
        r.taken = (a == b);
        r.target = pc_plus_four + immediate;
      end
      OP_BNE: begin
        r.is_branch = 1'b1;
        r.taken = (a != b);
        r.target = pc_plus_four + immediate;
      end
      OP_J: begin
        r.is_branch = 1'b1;
        r.taken = 1'b1;
        r.target = jump_target;
      end
      OP_OTHER_R: r.dest_index = rd_index;
      OP_OTHER_I: r.dest_index = rt_index;
      default: begin
        if (is_load) begin
          r.alu_value = a + immediate;
          r.dest_index = rt_index;
        end else if (op >= OP_STORE_FIRST && op <= OP_STORE_LAST) begin
          r.alu_value = a + immediate;
        end
      end
    endcase
    last_alu = r.alu_value;
    last_was_load = is_load;
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t, result %0d: %s", $realtime, result_index, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [DataWidth-1:0] got,
                               logic [DataWidth-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%08h, expected 0x%08h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    exec_result_t predicted;
    if (rst) begin
      last_alu = '0;
      last_was_load = 1'b0;
      older_alu = '0;
      older_was_load = 1'b0;
      predicted_results.delete();
    end else begin
      if (valid && !stall) begin
        execute_slot(predicted);
        predicted_results.push_back(predicted);
      end
      if (res_valid && !res_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result transfer with no result outstanding");
        end else begin
          predicted = predicted_results.pop_front();
          compare_field("out_valid", out_valid, predicted.out_valid);
          compare_field("alu_value", alu_value, predicted.alu_value);
          compare_field("store_value", store_value, predicted.store_value);
          compare_field("dest_index", dest_index, predicted.dest_index);
          compare_field("is_branch", is_branch, predicted.is_branch);
          compare_field("taken", taken, predicted.taken);
          compare_field("target", target, predicted.target);
        end
        result_index++;
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import mipsex_pkg::*; ();

  localparam logic [OpWidth-1:0]  OP_OTHER_NONE = 5'd26;
  localparam logic [OpWidth-1:0]  OP_CODE_MAX   = 5'd31;
  localparam logic [SelWidth-1:0] FWD_SPARE     = 2'd3;
  localparam int RandomSlots   = 1425;
  localparam int TimeoutCycles = 200000;
  localparam int DrainCycles   = 4;

  typedef struct packed {
    logic                     in_valid;
    logic [OpWidth-1:0]       op;
    logic [DataWidth-1:0]     reg_value_a;
    logic [DataWidth-1:0]     reg_value_b;
    logic [SelWidth-1:0]      forward_sel_a;
    logic [SelWidth-1:0]      forward_sel_b;
    logic [DataWidth-1:0]     immediate;
    logic [RegIndexWidth-1:0] rd_index;
    logic [RegIndexWidth-1:0] rt_index;
    logic [DataWidth-1:0]     pc_plus_four;
    logic [DataWidth-1:0]     jump_target;
    logic [DataWidth-1:0]     load_data_two_back;
  } exec_slot_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     valid = 1'b0;
  logic                     stall;
  logic                     in_valid = 1'b0;
  logic [OpWidth-1:0]       op = '0;
  logic [DataWidth-1:0]     reg_value_a = '0;
  logic [DataWidth-1:0]     reg_value_b = '0;
  logic [SelWidth-1:0]      forward_sel_a = '0;
  logic [SelWidth-1:0]      forward_sel_b = '0;
  logic [DataWidth-1:0]     immediate = '0;
  logic [RegIndexWidth-1:0] rd_index = '0;
  logic [RegIndexWidth-1:0] rt_index = '0;
  logic [DataWidth-1:0]     pc_plus_four = '0;
  logic [DataWidth-1:0]     jump_target = '0;
  logic [DataWidth-1:0]     load_data_two_back = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic                     out_valid;
  logic [DataWidth-1:0]     alu_value;
  logic [DataWidth-1:0]     store_value;
  logic [RegIndexWidth-1:0] dest_index;
  logic                     is_branch;
  logic                     taken;
  logic [DataWidth-1:0]     target;

  logic idle_en = 1'b1;
  int   mismatch_count;
  int   outstanding;
  int   cycle_count = 0;

  mips_execute_stage_forwarding u_top (
    .clk, .rst, .valid, .stall, .in_valid, .op, .reg_value_a, .reg_value_b,
    .forward_sel_a, .forward_sel_b, .immediate, .rd_index, .rt_index,
    .pc_plus_four, .jump_target, .load_data_two_back, .res_valid, .res_stall,
    .out_valid, .alu_value, .store_value, .dest_index, .is_branch, .taken, .target
  );

  execute_result_checker u_checker (
    .clk, .rst, .valid, .stall, .in_valid, .op, .reg_value_a, .reg_value_b,
    .forward_sel_a, .forward_sel_b, .immediate, .rd_index, .rt_index,
    .pc_plus_four, .jump_target, .load_data_two_back, .res_valid, .res_stall,
    .out_valid, .alu_value, .store_value, .dest_index, .is_branch, .taken, .target,
    .mismatch_count, .outstanding
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= idle_en && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TimeoutCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Selects lean toward forwarding so that the history paths see most of the traffic.
  function automatic logic [SelWidth-1:0] random_select();
    int roll;
    roll = $urandom_range(9);
    if (roll < 3) return FWD_REG;
    if (roll < 6) return FWD_PREV;
    if (roll < 9) return FWD_OLDER;
    return FWD_SPARE;
  endfunction

  function automatic exec_slot_t random_slot();
    exec_slot_t s;
    logic [DataWidth-1:0] raw;
    raw = $urandom;
    s.in_valid = ($urandom_range(99) >= 10);
    if ($urandom_range(99) < 90) begin
      s.op = OpWidth'($urandom_range(OP_OTHER_NONE));
    end else begin
      s.op = OpWidth'($urandom_range(OP_CODE_MAX, OP_OTHER_NONE + 1));
    end
    s.reg_value_a = $urandom;
    s.reg_value_b = ($urandom_range(3) == 0) ? s.reg_value_a : $urandom;
    s.forward_sel_a = random_select();
    s.forward_sel_b = ($urandom_range(3) == 0) ? s.forward_sel_a : random_select();
    s.immediate = $urandom_range(1) ? raw : {{(DataWidth-16){raw[15]}}, raw[15:0]};
    s.rd_index = RegIndexWidth'($urandom);
    s.rt_index = RegIndexWidth'($urandom);
    s.pc_plus_four = $urandom;
    s.jump_target = $urandom;
    s.load_data_two_back = $urandom;
    return s;
  endfunction

  task automatic send_slot(exec_slot_t s);
    valid <= 1'b1;
    in_valid <= s.in_valid;
    op <= s.op;
    reg_value_a <= s.reg_value_a;
    reg_value_b <= s.reg_value_b;
    forward_sel_a <= s.forward_sel_a;
    forward_sel_b <= s.forward_sel_b;
    immediate <= s.immediate;
    rd_index <= s.rd_index;
    rt_index <= s.rt_index;
    pc_plus_four <= s.pc_plus_four;
    jump_target <= s.jump_target;
    load_data_two_back <= s.load_data_two_back;
    do @(posedge clk); while (stall);
    while (idle_en && ($urandom_range(99) < 21)) begin
      valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_op(logic [OpWidth-1:0] code, logic [SelWidth-1:0] sel_a,
                         logic [SelWidth-1:0] sel_b);
    exec_slot_t s;
    s = random_slot();
    s.in_valid = 1'b1;
    s.op = code;
    s.forward_sel_a = sel_a;
    s.forward_sel_b = sel_b;
    send_slot(s);
  endtask

  task automatic drain_results();
    valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    exec_slot_t s;
    while (rst) @(posedge clk);

    // A bubble carries garbage in every other field.
    s = random_slot();
    s.in_valid = 1'b0;
    send_slot(s);
    s = random_slot();
    s.in_valid = 1'b1;
    s.op = OP_ADD;
    s.reg_value_a = '1;
    s.reg_value_b = 32'd1;
    s.forward_sel_a = FWD_REG;
    s.forward_sel_b = FWD_REG;
    send_slot(s);
    send_op(OP_ADDU, FWD_PREV, FWD_REG);
    s.op = OP_ADDI;
    s.immediate = 32'h8000_0000;
    s.forward_sel_a = FWD_OLDER;
    send_slot(s);
    s.op = OP_SUB;
    s.reg_value_a = '0;
    s.forward_sel_a = FWD_REG;
    send_slot(s);
    send_op(OP_SUBU, FWD_PREV, FWD_OLDER);
    send_op(OP_AND, FWD_REG, FWD_PREV);
    s = random_slot();
    s.in_valid = 1'b1;
    s.op = OP_ANDI;
    s.immediate = '1;
    s.forward_sel_a = FWD_REG;
    send_slot(s);
    send_op(OP_OR, FWD_OLDER, FWD_REG);
    send_op(OP_ORI, FWD_PREV, FWD_REG);
    send_op(OP_XOR, FWD_REG, FWD_REG);
    send_op(OP_XORI, FWD_OLDER, FWD_PREV);
    s.op = OP_LUI;
    send_slot(s);
    // Two loads back to back, then a store whose operands both take the first load's data two slots later.
    send_op(OP_LOAD_FIRST, FWD_PREV, FWD_REG);
    send_op(OP_LOAD_LAST, FWD_OLDER, FWD_REG);
    send_op(OP_STORE_FIRST, FWD_OLDER, FWD_OLDER);
    send_op(OP_STORE_LAST, FWD_SPARE, FWD_SPARE);
    s = random_slot();
    s.in_valid = 1'b1;
    s.op = OP_BEQ;
    s.reg_value_b = s.reg_value_a;
    s.forward_sel_a = FWD_REG;
    s.forward_sel_b = FWD_REG;
    send_slot(s);
    s.reg_value_b = ~s.reg_value_a;
    send_slot(s);
    s.op = OP_BNE;
    s.reg_value_b = s.reg_value_a;
    send_slot(s);
    send_op(OP_J, FWD_PREV, FWD_OLDER);
    send_op(OP_OTHER_R, FWD_REG, FWD_PREV);
    send_op(OP_OTHER_I, FWD_OLDER, FWD_REG);
    send_op(OP_OTHER_NONE, FWD_PREV, FWD_PREV);
    send_op(OP_CODE_MAX, FWD_REG, FWD_OLDER);
    drain_results();

    for (int i = 0; i < RandomSlots; i++) begin
      idle_en <= !(i >= 500 && i < 800);
      if (i == 1000) begin
        drain_results();
      end
      send_slot(random_slot());
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
